>>> rtl/dnsq_pkg.sv
package dnsq_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [15:0] word_t;

  localparam int RegIndexW = 2;
  typedef logic [RegIndexW-1:0] reg_index_t;

  localparam reg_index_t REG_TRANSACTION_ID = 2'd0;
  localparam reg_index_t REG_HEADER_FLAGS   = 2'd1;
  localparam reg_index_t REG_QUERY_TYPE     = 2'd2;
  localparam reg_index_t REG_QUERY_CLASS    = 2'd3;

  localparam word_t TRANSACTION_ID_RST = 16'hAAAA;
  localparam word_t HEADER_FLAGS_RST   = 16'h0100;
  localparam word_t QUERY_TYPE_RST     = 16'h0001;
  localparam word_t QUERY_CLASS_RST    = 16'h0001;

  localparam byte_t SEPARATOR = 8'h2E;

  // header and trailer sizes in bytes
  localparam int HdrBytes  = 12;
  localparam int TailBytes = 5;

endpackage

>>> rtl/dnsq_char_if.sv
interface dnsq_char_if;
  logic           valid;
  logic           ready;
  dnsq_pkg::byte_t char_code;
  logic           name_end;

  modport source (output valid, output char_code, output name_end, input ready);
  modport sink (input valid, input char_code, input name_end, output ready);
endinterface

>>> rtl/dnsq_pair_if.sv
interface dnsq_pair_if;
  logic           valid;
  logic           ready;
  dnsq_pkg::byte_t first_byte;
  dnsq_pkg::byte_t second_byte;
  logic           second_valid;
  logic           run_last;
  logic           packet_end;
  logic           label_too_long;

  modport source (
    output valid, output first_byte, output second_byte, output second_valid,
    output run_last, output packet_end, output label_too_long, input ready
  );
  modport sink (
    input valid, input first_byte, input second_byte, input second_valid,
    input run_last, input packet_end, input label_too_long, output ready
  );
endinterface

>>> rtl/dns_query_packet_builder_core.sv
// DNS query builder: takes a domain name one character per beat on chars and
// emits the query packet as byte pairs on pairs. The first character of a name
// sends the 12-byte header, a dot or the name_end character flushes the current
// label (length byte, then the label bytes from a MAX_LABEL-entry store with
// one registered read port), and name_end adds the zero terminator, query type
// and query class. An odd byte left over at the end of a non-final character
// is held and leads the next beat's output. A character that produces no bytes
// leaves the block idle; otherwise one byte sequencer emits one packet byte
// per cycle while the pair output register is free, and waits whenever that
// register is held by a stalled sink. chars.ready is low until the last byte
// of an item is issued. The user must write configuration (wr_en, wr_index,
// wr_data) only while idle; the block itself does not enforce it.
module dns_query_packet_builder_core #(
  parameter int MAX_LABEL = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  dnsq_char_if.sink                   chars,
  dnsq_pair_if.source                 pairs,
  input  logic                        wr_en,
  input  dnsq_pkg::reg_index_t        wr_index,
  input  dnsq_pkg::word_t             wr_data
);

  localparam int CW      = $clog2(MAX_LABEL + 1);
  localparam int AW      = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int SUB_MAX = (MAX_LABEL > dnsq_pkg::HdrBytes) ? MAX_LABEL : dnsq_pkg::HdrBytes;
  localparam int SW      = $clog2(SUB_MAX);
  localparam int NW      = $clog2(MAX_LABEL + dnsq_pkg::HdrBytes + dnsq_pkg::TailBytes + 4);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HELD, PH_HDR, PH_LEN, PH_LAB, PH_TAIL
  } phase_t;

  // config registers
  dnsq_pkg::word_t transaction_id, header_flags, query_type, query_class;

  // block state
  dnsq_pkg::byte_t store [MAX_LABEL];
  dnsq_pkg::byte_t rd_data;
  logic [CW-1:0]   label_count;
  logic            overflow_seen;
  logic            header_sent;
  dnsq_pkg::byte_t held_byte;
  logic            held_valid;

  // sequencer
  phase_t          phase, phase_next;
  logic [SW-1:0]   sub, sub_next;
  logic [NW-1:0]   bi;
  logic [NW-1:0]   total_n;
  logic [NW-1:0]   emit_n;
  logic [CW-1:0]   flush_len, flush_len_next;
  logic [1:0]      flushes, flushes_next;
  logic            do_hdr;
  logic            end_l;
  dnsq_pkg::byte_t pair_first;

  // output register
  logic            o_valid;
  dnsq_pkg::byte_t o_first, o_second;
  logic            o_sv, o_last, o_pend, o_ov;

  function automatic phase_t first_phase(input logic held, input logic hdr, input logic fl);
    phase_t p;
    if (held) p = PH_HELD;
    else if (hdr) p = PH_HDR;
    else if (fl) p = PH_LEN;
    else p = PH_TAIL;
    return p;
  endfunction

  // accept-time decode
  logic            accept;
  logic            is_dot;
  logic            room;
  logic [CW-1:0]   count_new;
  logic [CW-1:0]   fl_b_len;
  logic [NW-1:0]   n_calc;
  logic            hold_calc;
  logic [1:0]      flushes_calc;

  assign accept = chars.valid && chars.ready;
  assign is_dot = (chars.char_code == dnsq_pkg::SEPARATOR);
  assign room   = (32'(label_count) < 32'(MAX_LABEL));
  assign count_new = room ? label_count + CW'(1) : label_count;
  assign fl_b_len  = is_dot ? '0 : count_new;
  assign flushes_calc = 2'(is_dot) + 2'(chars.name_end);

  always_comb begin
    n_calc = NW'(held_valid);
    if (!header_sent) n_calc = n_calc + NW'(dnsq_pkg::HdrBytes);
    if (is_dot) n_calc = n_calc + NW'(label_count) + NW'(1);
    if (chars.name_end) n_calc = n_calc + NW'(fl_b_len) + NW'(dnsq_pkg::TailBytes + 1);
  end
  assign hold_calc = !chars.name_end && n_calc[0] && (n_calc > NW'(1));

  // byte issue
  logic            slot_free;
  logic            advance;
  logic            in_emit;
  logic            completes;
  logic            final_byte;
  logic            pair_load;
  dnsq_pkg::byte_t cur_byte;

  assign slot_free  = !o_valid || pairs.ready;
  assign advance    = (phase != PH_IDLE) && slot_free;
  assign in_emit    = (bi < emit_n);
  assign completes  = bi[0] || (bi == emit_n - NW'(1));
  assign final_byte = (bi == total_n - NW'(1));
  assign pair_load  = advance && in_emit && completes;

  always_comb begin
    cur_byte = '0;
    case (phase)
      PH_HELD: cur_byte = held_byte;
      PH_HDR: begin
        case (sub[3:0])
          4'd0: cur_byte = transaction_id[15:8];
          4'd1: cur_byte = transaction_id[7:0];
          4'd2: cur_byte = header_flags[15:8];
          4'd3: cur_byte = header_flags[7:0];
          4'd5: cur_byte = 8'h01;  // one question
          default: cur_byte = '0;
        endcase
      end
      PH_LEN: cur_byte = 8'(flush_len);
      PH_LAB: cur_byte = rd_data;
      PH_TAIL: begin
        case (sub[2:0])
          3'd1: cur_byte = query_type[15:8];
          3'd2: cur_byte = query_type[7:0];
          3'd3: cur_byte = query_class[15:8];
          3'd4: cur_byte = query_class[7:0];
          default: cur_byte = '0;  // name terminator
        endcase
      end
      default: cur_byte = '0;
    endcase
  end

  // next phase within an item
  always_comb begin
    phase_next     = phase;
    sub_next       = sub;
    flush_len_next = flush_len;
    flushes_next   = flushes;
    if (accept) begin
      phase_next     = (n_calc != '0)
                       ? first_phase(held_valid, !header_sent, flushes_calc != 2'd0)
                       : PH_IDLE;
      sub_next       = '0;
      flush_len_next = is_dot ? label_count : count_new;
      flushes_next   = flushes_calc;
    end else if (advance) begin
      if (final_byte) begin
        phase_next = PH_IDLE;
        sub_next   = '0;
      end else begin
        case (phase)
          PH_HELD: begin
            phase_next = first_phase(1'b0, do_hdr, flushes != 2'd0);
            sub_next   = '0;
          end
          PH_HDR: begin
            if (sub == SW'(dnsq_pkg::HdrBytes - 1)) begin
              phase_next = first_phase(1'b0, 1'b0, flushes != 2'd0);
              sub_next   = '0;
            end else begin
              sub_next = sub + SW'(1);
            end
          end
          PH_LEN: begin
            sub_next = '0;
            if (flush_len == '0) begin
              // empty label: only the zero length byte
              flushes_next = flushes - 2'd1;
              phase_next   = (flushes > 2'd1) ? PH_LEN : PH_TAIL;
            end else begin
              phase_next = PH_LAB;
            end
          end
          PH_LAB: begin
            if ((32'(sub) + 32'd1) == 32'(flush_len)) begin
              flushes_next   = flushes - 2'd1;
              flush_len_next = '0;
              phase_next     = (flushes > 2'd1) ? PH_LEN : PH_TAIL;
              sub_next       = '0;
            end else begin
              sub_next = sub + SW'(1);
            end
          end
          PH_TAIL: sub_next = sub + SW'(1);
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // label store: write on accept, read addressed from sub_next so the registered data is ready when used
  logic [AW-1:0] rd_addr;
  assign rd_addr = (32'(sub_next) < 32'(MAX_LABEL)) ? AW'(sub_next) : '0;

  always_ff @(posedge clk) begin
    if (accept && !is_dot && room) begin
      store[AW'(label_count)] <= chars.char_code;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_id <= dnsq_pkg::TRANSACTION_ID_RST;
      header_flags   <= dnsq_pkg::HEADER_FLAGS_RST;
      query_type     <= dnsq_pkg::QUERY_TYPE_RST;
      query_class    <= dnsq_pkg::QUERY_CLASS_RST;
      label_count    <= '0;
      overflow_seen  <= 1'b0;
      header_sent    <= 1'b0;
      held_valid     <= 1'b0;
      held_byte      <= '0;
      phase          <= PH_IDLE;
      sub            <= '0;
      bi             <= '0;
      flush_len      <= '0;
      flushes        <= '0;
      o_valid        <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          dnsq_pkg::REG_TRANSACTION_ID: transaction_id <= wr_data;
          dnsq_pkg::REG_HEADER_FLAGS:   header_flags   <= wr_data;
          dnsq_pkg::REG_QUERY_TYPE:     query_type     <= wr_data;
          dnsq_pkg::REG_QUERY_CLASS:    query_class    <= wr_data;
          default: ;
        endcase
      end

      phase     <= phase_next;
      sub       <= sub_next;
      flush_len <= flush_len_next;
      flushes   <= flushes_next;

      if (pair_load) o_valid <= 1'b1;
      else if (pairs.ready) o_valid <= 1'b0;

      if (accept) begin
        label_count   <= (is_dot || chars.name_end) ? '0 : count_new;
        overflow_seen <= (header_sent && overflow_seen) || (!is_dot && !room);
        header_sent   <= !chars.name_end;
        held_valid    <= 1'b0;
        do_hdr        <= !header_sent;
        end_l         <= chars.name_end;
        total_n       <= n_calc;
        emit_n        <= hold_calc ? n_calc - NW'(1) : n_calc;
        bi            <= '0;
      end else if (advance) begin
        bi <= bi + NW'(1);
        if (in_emit) begin
          if (completes) begin
            o_first  <= bi[0] ? pair_first : cur_byte;
            o_second <= bi[0] ? cur_byte : '0;
            o_sv     <= bi[0];
            o_last   <= (bi == emit_n - NW'(1));
            o_pend   <= (bi == emit_n - NW'(1)) && end_l;
            o_ov     <= overflow_seen;
          end else begin
            pair_first <= cur_byte;
          end
        end else begin
          // odd leftover byte waits for the next character
          held_byte  <= cur_byte;
          held_valid <= 1'b1;
        end
      end
    end
  end

  assign chars.ready          = (phase == PH_IDLE);
  assign pairs.valid          = o_valid;
  assign pairs.first_byte     = o_first;
  assign pairs.second_byte    = o_second;
  assign pairs.second_valid   = o_sv;
  assign pairs.run_last       = o_last;
  assign pairs.packet_end     = o_pend;
  assign pairs.label_too_long = o_ov;

endmodule
